FILE: sv/bld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list deque package
// Shared widths, request kinds, result codes and memory control types.
// ----------------------------------------------------------------------------
package bld_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KIND_W    = 3;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 2;

    // Request kinds; the remaining codes are accepted and do nothing.
    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 3'd0,
        K_APPEND = 3'd1,
        K_REMOVE = 3'd2,
        K_DUMP   = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    // Result codes.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_DUMPED = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Strobes from the controller to the element memory.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

FILE: sv/bld_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module bld_store
    import bld_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int SW = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_mem,
    input  logic [SW-1:0]            i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata,
    input  logic [SW-1:0]            i_raddr,
    output logic signed [DATA_W-1:0] o_rdata
);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_mem.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read, which the controller relies on.
    always_ff @(posedge i_clk) begin
        if (i_mem.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bld_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque controller
// Head and count registers, request decode, dump sequencer and result register.
// ----------------------------------------------------------------------------
module bld_ctrl
    import bld_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int SW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_item,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_last,
    output t_mem_ctl                 o_mem,
    output logic [SW-1:0]            o_waddr,
    output logic signed [DATA_W-1:0] o_wdata,
    output logic [SW-1:0]            o_raddr,
    input  logic signed [DATA_W-1:0] i_rdata
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state                   r_state, n_state;
    logic [SW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;
    logic [SW-1:0]            r_addr, n_addr;
    logic [CW-1:0]            r_rem, n_rem;
    logic                     r_rd_pend, n_rd_pend;
    logic                     r_rd_last, n_rd_last;
    logic                     r_o_valid, n_o_valid;
    logic signed [DATA_W-1:0] r_o_item, n_o_item;
    t_status                  r_o_status, n_o_status;
    logic                     r_o_last, n_o_last;

    logic          out_free;
    logic          accept;
    logic          full;
    logic          empty;
    logic          issue;
    logic          move;
    logic [SW-1:0] head_dec;
    logic [SW-1:0] head_inc;
    logic [SW-1:0] addr_inc;
    logic [CW:0]   tail_sum;
    logic [SW-1:0] tail_slot;

    function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        if (s == SW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + SW'(1);
        end
        return r;
    endfunction

    assign out_free = !r_o_valid || !i_stall;
    assign accept   = i_valid && (r_state == S_IDLE) && out_free;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);

    assign head_dec  = (r_head == '0) ? SW'(DEPTH - 1) : r_head - SW'(1);
    assign head_inc  = inc_slot(r_head);
    assign addr_inc  = inc_slot(r_addr);
    assign tail_sum  = (CW + 1)'(r_head) + (CW + 1)'(r_count);
    assign tail_slot = (tail_sum >= (CW + 1)'(DEPTH)) ?
                       SW'(tail_sum - (CW + 1)'(DEPTH)) : SW'(tail_sum);

    // A read is issued when its data will find room: the memory output is
    // either free or being moved into the result register this cycle.
    assign issue = (r_state == S_DUMP) && (r_rem != '0) && (!r_rd_pend || out_free);
    assign move  = (r_state == S_DUMP) && r_rd_pend && out_free;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_addr     = r_addr;
        n_rem      = r_rem;
        n_rd_pend  = r_rd_pend;
        n_rd_last  = r_rd_last;
        n_o_valid  = r_o_valid && i_stall;
        n_o_item   = r_o_item;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        o_mem      = '0;
        o_waddr    = head_dec;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_o_valid  = 1'b1;
                    n_o_item   = '0;
                    n_o_status = ST_DONE;
                    n_o_last   = 1'b1;
                    case (t_kind'(i_kind))
                        K_INSERT: begin
                            if (full) begin
                                n_o_status = ST_FULL;
                            end else begin
                                o_mem.we = 1'b1;
                                n_head   = head_dec;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        K_APPEND: begin
                            if (full) begin
                                n_o_status = ST_FULL;
                            end else begin
                                o_mem.we = 1'b1;
                                o_waddr  = tail_slot;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        K_REMOVE: begin
                            if (empty) begin
                                n_o_status = ST_EMPTY;
                            end else begin
                                n_head  = head_inc;
                                n_count = r_count - CW'(1);
                            end
                        end
                        K_DUMP: begin
                            if (empty) begin
                                n_o_status = ST_EMPTY;
                            end else begin
                                n_o_valid = 1'b0;
                                n_state   = S_DUMP;
                                n_addr    = r_head;
                                n_rem     = r_count;
                            end
                        end
                        K_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (move) begin
                    n_o_valid  = 1'b1;
                    n_o_item   = i_rdata;
                    n_o_status = ST_DUMPED;
                    n_o_last   = r_rd_last;
                    n_rd_pend  = 1'b0;
                    if (r_rd_last) begin
                        n_state = S_IDLE;
                    end
                end
                if (issue) begin
                    o_mem.re  = 1'b1;
                    n_addr    = addr_inc;
                    n_rem     = r_rem - CW'(1);
                    n_rd_pend = 1'b1;
                    n_rd_last = (r_rem == CW'(1));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_rem     <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_rem     <= n_rem;
            r_rd_pend <= n_rd_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_rd_last  <= n_rd_last;
        r_o_item   <= n_o_item;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_valid  = r_o_valid;
    assign o_item   = r_o_item;
    assign o_status = r_o_status;
    assign o_last   = r_o_last;
    assign o_wdata  = i_value;
    assign o_raddr  = r_addr;

endmodule

FILE: sv/bounded_list_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list deque
// Ordered list of up to DEPTH signed words held in a ring memory.
// ----------------------------------------------------------------------------
// Usage. The request channel (i_valid, o_stall, i_kind, i_value) carries one
// beat per request: insert at head, append at tail, remove head, dump or
// clear. The result channel (o_valid, i_stall, o_item, o_status, o_last)
// returns one beat for every request, except a dump of a non-empty list,
// which returns one beat per element from head to tail with o_last on the
// final one. Every other result beat has o_last set and o_item at zero.
// A single-beat result is registered at the edge that takes the request.
// A dump of N elements holds the request channel until its last element
// has moved into the result register, since each element is first read
// from the ring memory with a registered read and then streamed at one
// per cycle while the receiver does not stall.
// A new request is taken while the result register is empty or being
// emptied, and never while a dump is in progress.
// If the receiver stalls, the result beat holds and o_stall rises; a dump
// pauses its memory reads until the beat is taken. Reset empties the list
// at once and drops any pending result; memory contents are left as they
// are, as only written slots are ever read.
// ----------------------------------------------------------------------------
module bounded_list_deque_top
    import bld_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_item,
    output logic [STAT_W-1:0]        o_status,
    output logic                     o_last
);

    localparam int SW = $clog2(DEPTH);

    // Memory port between the controller and the ring store.
    t_mem_ctl                 mem_ctl;
    logic [SW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [SW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    // The controller owns the head slot, the count and the result register.
    bld_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item),
        .o_status (o_status),
        .o_last   (o_last),
        .o_mem    (mem_ctl),
        .o_waddr  (mem_waddr),
        .o_wdata  (mem_wdata),
        .o_raddr  (mem_raddr),
        .i_rdata  (mem_rdata)
    );

    // The elements themselves live in a plain memory with a registered read.
    bld_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_mem   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: sv/bld_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module bld_chk
    import bld_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [DATA_W-1:0] o_item,
    input logic [STAT_W-1:0]        o_status,
    input logic                     o_last
);

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Only dumped elements carry a value.
    a_item_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DUMPED) |-> (o_item == '0))
        else $error("non-dump result with non-zero item");

    // Only a dump can give more than one result.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DUMPED) |-> o_last)
        else $error("non-dump result without last");

    // No request is taken while a dump is still streaming.
    a_dump_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("request taken during a dump");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item) && $stable(o_status)
            && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind bounded_list_deque_top bld_chk u_bld_chk (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list deque testbench
// Drives request beats into the deque and checks every result beat against a
// behavioural copy of the list that is kept inside the testbench. Directed
// corner cases come first, then a full-list pass, a back-pressure pass and a
// short stretch of random requests, mostly with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import bld_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_LONG    = 150;
    localparam int RANDOM_ITEMS = 8;

    // Kind codes that the block accepts but treats as no operation.
    localparam logic [KIND_W-1:0] K_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] K_UNUSED_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // One expected result beat.
    typedef struct {
        logic signed [DATA_W-1:0] item;
        t_status                  status;
        logic                     last;
    } t_result;

    // Clock, reset and ports. Every input starts at a known value.
    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [KIND_W-1:0]        i_kind  = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_item;
    logic [STAT_W-1:0]        o_status;
    logic                     o_last;

    // Behavioural copy of the list: ring of slots, head slot and length.
    logic signed [DATA_W-1:0] deque_slots [DEPTH];
    logic [5:0]               deque_head  = '0;
    logic [6:0]               deque_count = '0;

    // Result beats predicted but not yet seen, oldest first.
    t_result pending_results [$];

    int mismatch_count = 0;

    // Idling controls. The calm flags switch random gaps off on one side;
    // hold_left, when set, keeps the receiver stalled until it counts down to zero.
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    int hold_left   = 0;
    int rx_run      = 0;
    bit rx_stalling = 1'b0;

    bounded_list_deque_top #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item),
        .o_status (o_status),
        .o_last   (o_last)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Idle stretch length: mostly short, now and then a long one.
    function automatic int pick_idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(15, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Element values lean on the extremes so that sign and wrap are exercised.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void push_result(input logic signed [DATA_W-1:0] item,
                                        input t_status status,
                                        input logic last);
        t_result r;
        r.item   = item;
        r.status = status;
        r.last   = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Applies one accepted request to the copy of the list and queues the
    // result beats that the block must return for it.
    function automatic void predict_deque_results(input logic [KIND_W-1:0] kind,
                                                  input logic signed [DATA_W-1:0] value);
        int i;
        logic [5:0] slot;
        case (kind)
            K_INSERT, K_APPEND: begin
                if (deque_count >= DEPTH) begin
                    push_result('0, ST_FULL, 1'b1);
                end else begin
                    if (kind == K_INSERT) begin
                        deque_head = 6'((int'(deque_head) + DEPTH - 1) % DEPTH);
                        deque_slots[deque_head] = value;
                    end else begin
                        slot = 6'((int'(deque_head) + int'(deque_count)) % DEPTH);
                        deque_slots[slot] = value;
                    end
                    deque_count++;
                    push_result('0, ST_DONE, 1'b1);
                end
            end
            K_REMOVE: begin
                if (deque_count == 0) begin
                    push_result('0, ST_EMPTY, 1'b1);
                end else begin
                    deque_head = 6'((int'(deque_head) + 1) % DEPTH);
                    deque_count--;
                    push_result('0, ST_DONE, 1'b1);
                end
            end
            K_DUMP: begin
                if (deque_count == 0) begin
                    push_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < int'(deque_count); i++) begin
                        slot = 6'((int'(deque_head) + i) % DEPTH);
                        push_result(deque_slots[slot], ST_DUMPED,
                                    (i + 1 == int'(deque_count)));
                    end
                end
            end
            K_CLEAR: begin
                deque_count = '0;
                deque_head  = '0;
                push_result('0, ST_DONE, 1'b1);
            end
            default: begin
                push_result('0, ST_DONE, 1'b1);
            end
        endcase
    endfunction

    // Offers one request beat and waits until the block takes it. The task
    // starts and ends just after a rising edge. If a gap follows, valid drops
    // and the idle payload is scrambled, which the block must ignore.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        predict_deque_results(kind, value);
        gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_kind  <= KIND_W'($urandom);
            i_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted beat has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // A request drawn at random, mostly list updates with the occasional
    // dump, clear or unused code.
    task automatic send_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            send_request(K_INSERT, pick_value());
        end else if (r < 70) begin
            send_request(K_APPEND, pick_value());
        end else if (r < 88) begin
            send_request(K_REMOVE, pick_value());
        end else if (r < 94) begin
            send_request(K_DUMP, pick_value());
        end else if (r < 96) begin
            send_request(K_CLEAR, pick_value());
        end else begin
            send_request(KIND_W'($urandom_range(K_UNUSED_LO, K_UNUSED_HI)), pick_value());
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: drives i_stall. A requested hold takes priority and is counted
    // down here, one cycle at a time; otherwise stall and free runs alternate
    // at random unless the receiver is set calm.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_run = 0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (rx_calm) begin
            i_stall <= 1'b0;
        end else begin
            if (rx_run <= 0) begin
                rx_stalling = ($urandom_range(0, 2) == 0);
                rx_run = rx_stalling ? pick_idle_len() : $urandom_range(1, 8);
            end
            i_stall <= rx_stalling;
            rx_run--;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result beat is compared with the oldest
    // prediction. The values read here are those from before the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat item=%0d status=%0d last=%0b",
                                          o_item, o_status, o_last));
            end else begin
                want = pending_results.pop_front();
                if (o_item !== want.item || o_status !== want.status
                        || o_last !== want.last) begin
                    report_mismatch($sformatf(
                        "got item=%0d status=%0d last=%0b, want item=%0d status=%0d last=%0b",
                        o_item, o_status, o_last, want.item, want.status, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty-list flags, extreme values, head wrap from slot zero, every kind
    // including the unused codes, and clear followed by use.
    task automatic test_directed();
        int k;
        send_request(K_REMOVE, pick_value());
        send_request(K_DUMP, pick_value());
        send_request(K_INSERT, VAL_MAX);
        send_request(K_APPEND, VAL_MIN);
        send_request(K_INSERT, '0);
        send_request(K_APPEND, -1);
        send_request(K_DUMP, '0);
        send_request(K_REMOVE, '0);
        send_request(K_DUMP, '0);
        for (k = K_UNUSED_LO; k <= K_UNUSED_HI; k++) begin
            send_request(KIND_W'(k), $urandom);
        end
        send_request(K_DUMP, '0);
        send_request(K_CLEAR, $urandom);
        send_request(K_DUMP, '0);
        send_request(K_REMOVE, '0);
        send_request(K_APPEND, VAL_MAX);
        send_request(K_INSERT, VAL_MIN);
        send_request(K_DUMP, '0);
        send_request(K_CLEAR, '0);
        wait_drained();
    endtask

    // Fills the list to capacity, tries both kinds of add on a full list,
    // dumps all of it, takes a couple of elements off and clears it.
    task automatic test_full_list();
        int i;
        send_request(K_CLEAR, '0);
        for (i = 0; i < DEPTH; i++) begin
            send_request(($urandom_range(0, 1) == 0) ? K_INSERT : K_APPEND, pick_value());
        end
        send_request(K_INSERT, pick_value());
        send_request(K_APPEND, pick_value());
        send_request(K_DUMP, '0);
        send_request(K_REMOVE, '0);
        send_request(K_REMOVE, '0);
        send_request(K_CLEAR, '0);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back-to-back beats, so a dump and the requests behind it
    // pile up against a full result register. The sender then pauses until
    // everything has drained.
    task automatic test_back_pressure();
        int i;
        send_request(K_CLEAR, '0);
        for (i = 0; i < 8; i++) begin
            send_request(K_APPEND, pick_value());
        end
        wait_drained();
        tx_calm   = 1'b1;
        hold_left = HOLD_LONG;
        send_request(K_DUMP, '0);
        send_request(K_INSERT, pick_value());
        send_request(K_REMOVE, '0);
        send_request(K_DUMP, '0);
        for (i = 0; i < 4; i++) begin
            send_random_request();
        end
        tx_calm = 1'b0;
        wait_drained();
    endtask

    // Random requests, with calm stretches on either side switched in and
    // out every few beats.
    task automatic test_random_requests();
        int i;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 4 == 0) begin
                tx_calm = ($urandom_range(0, 2) == 0);
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            send_random_request();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, run every test in turn, let the block settle and
    // give the verdict.
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_list();
        test_back_pressure();
        test_random_requests();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("predicted beats never arrived");
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, so it only fires on a
    // hang.
    initial begin
        #(64'd50_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
